### hdl/vcsp_pkg.sv
// ----------------------------------------------------------------------------
// vcsp_pkg: shared types and codes for the voxel chunk stream parser
// Field widths, result kinds, fault codes, chunk classes and tags, the result record and the tag classifier.
// ----------------------------------------------------------------------------
package vcsp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned DIM_W   = 31;
  localparam int unsigned COLOR_W = 7;
  localparam int unsigned FAULT_W = 4;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CK_W    = 3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SIZE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_VOXEL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUPPK = 3'd4;

  // fault codes
  localparam logic [FAULT_W-1:0] FLT_BAD_MAGIC    = 4'd0;
  localparam logic [FAULT_W-1:0] FLT_VERSION_EOF  = 4'd1;
  localparam logic [FAULT_W-1:0] FLT_NO_MODELS    = 4'd2;
  localparam logic [FAULT_W-1:0] FLT_HEADER_EOF   = 4'd3;
  localparam logic [FAULT_W-1:0] FLT_PACK_EOF     = 4'd4;
  localparam logic [FAULT_W-1:0] FLT_SIZE_EOF     = 4'd5;
  localparam logic [FAULT_W-1:0] FLT_SIZE_NONPOS  = 4'd6;
  localparam logic [FAULT_W-1:0] FLT_VOX_NO_SIZE  = 4'd7;
  localparam logic [FAULT_W-1:0] FLT_COUNT_EOF    = 4'd8;
  localparam logic [FAULT_W-1:0] FLT_ZERO_VOXELS  = 4'd9;
  localparam logic [FAULT_W-1:0] FLT_VOXEL_EOF    = 4'd10;
  localparam logic [FAULT_W-1:0] FLT_COLOR_NEG    = 4'd11;
  localparam logic [FAULT_W-1:0] FLT_COUNT_MISM   = 4'd12;

  // chunk classes
  localparam logic [CK_W-1:0] CK_OTHER = 3'd0;
  localparam logic [CK_W-1:0] CK_MAIN  = 3'd1;
  localparam logic [CK_W-1:0] CK_PACK  = 3'd2;
  localparam logic [CK_W-1:0] CK_SIZE  = 3'd3;
  localparam logic [CK_W-1:0] CK_XYZI  = 3'd4;
  localparam logic [CK_W-1:0] CK_RGBA  = 3'd5;

  // four-character tags, first character in the low byte
  localparam logic [WORD_W-1:0] TAG_VOX  = 32'h2058_4F56;
  localparam logic [WORD_W-1:0] TAG_MAIN = 32'h4E49_414D;
  localparam logic [WORD_W-1:0] TAG_PACK = 32'h4B43_4150;
  localparam logic [WORD_W-1:0] TAG_SIZE = 32'h455A_4953;
  localparam logic [WORD_W-1:0] TAG_XYZI = 32'h495A_5958;
  localparam logic [WORD_W-1:0] TAG_RGBA = 32'h4142_4752;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DIM_W-1:0]   dim_x;
    logic [DIM_W-1:0]   dim_y;
    logic [DIM_W-1:0]   dim_z;
    logic [BYTE_W-1:0]  vox_x;
    logic [BYTE_W-1:0]  vox_y;
    logic [BYTE_W-1:0]  vox_z;
    logic [COLOR_W-1:0] colour;
    logic [FAULT_W-1:0] fault;
    logic [WORD_W-1:0]  models_seen;
  } res_t;

  function automatic logic [CK_W-1:0] classify(input logic [WORD_W-1:0] id);
    logic [CK_W-1:0] ck;
    priority if (id == TAG_MAIN) ck = CK_MAIN;
    else if (id == TAG_PACK)     ck = CK_PACK;
    else if (id == TAG_SIZE)     ck = CK_SIZE;
    else if (id == TAG_XYZI)     ck = CK_XYZI;
    else if (id == TAG_RGBA)     ck = CK_RGBA;
    else                         ck = CK_OTHER;
    return ck;
  endfunction

endpackage

### hdl/vcsp_in_if.sv
// ----------------------------------------------------------------------------
// vcsp_in_if: file byte channel
// Valid/ready channel carrying one file byte or an end-of-file mark per word.
// ----------------------------------------------------------------------------
interface vcsp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [vcsp_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

### hdl/vcsp_out_if.sv
// ----------------------------------------------------------------------------
// vcsp_out_if: parser result channel
// Valid/ready channel carrying one parse result record per word.
// ----------------------------------------------------------------------------
interface vcsp_out_if;
  logic                         valid;
  logic                         ready;
  logic [vcsp_pkg::KIND_W-1:0]  kind;
  logic [vcsp_pkg::DIM_W-1:0]   dim_x;
  logic [vcsp_pkg::DIM_W-1:0]   dim_y;
  logic [vcsp_pkg::DIM_W-1:0]   dim_z;
  logic [vcsp_pkg::BYTE_W-1:0]  vox_x;
  logic [vcsp_pkg::BYTE_W-1:0]  vox_y;
  logic [vcsp_pkg::BYTE_W-1:0]  vox_z;
  logic [vcsp_pkg::COLOR_W-1:0] colour;
  logic [vcsp_pkg::FAULT_W-1:0] fault;
  logic [vcsp_pkg::WORD_W-1:0]  models_seen;

  modport source (output valid, output kind, output dim_x, output dim_y, output dim_z,
                  output vox_x, output vox_y, output vox_z, output colour, output fault,
                  output models_seen, input ready);
  modport sink   (input valid, input kind, input dim_x, input dim_y, input dim_z,
                  input vox_x, input vox_y, input vox_z, input colour, input fault,
                  input models_seen, output ready);
endinterface

### hdl/vox_chunk_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// vox_chunk_stream_parser_unit: voxel chunk file parser
// Path: a word accepted into the input register is stepped by the parser, and
//   any result it makes is written to the result register when it advances.
// Throughput: one word per cycle while no result is held back; a word with no
//   result advances while a result waits, one with a result waits for room.
// Reset (rst_ni low, async): parser returns to the magic check, counters and
//   held values clear, both pipeline registers go empty.
// ----------------------------------------------------------------------------
module vox_chunk_stream_parser_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  vcsp_in_if.sink           in_i,
  vcsp_out_if.source        out_o
);

  // parser phases
  localparam logic [3:0] PH_MAGIC   = 4'd0;
  localparam logic [3:0] PH_VERSION = 4'd1;
  localparam logic [3:0] PH_HEADER  = 4'd2;
  localparam logic [3:0] PH_PACK    = 4'd3;
  localparam logic [3:0] PH_SIZE    = 4'd4;
  localparam logic [3:0] PH_COUNT   = 4'd5;
  localparam logic [3:0] PH_VOXEL   = 4'd6;
  localparam logic [3:0] PH_SKIP    = 4'd7;
  localparam logic [3:0] PH_HALT    = 4'd8;

  // ---- input register ------------------------------------------------------
  logic                        in_valid_q;
  logic                        mode_q;
  logic [vcsp_pkg::BYTE_W-1:0] byte_q;

  // ---- parser state ---------------------------------------------------------
  logic [3:0]                  phase_q, phase_d;
  logic [3:0]                  bpos_q, bpos_d;
  logic [vcsp_pkg::WORD_W-1:0] acc_q, acc_d;
  logic [vcsp_pkg::CK_W-1:0]   ckind_q, ckind_d;
  logic [vcsp_pkg::WORD_W-1:0] clen_q, clen_d;
  logic [vcsp_pkg::WORD_W-1:0] remain_q, remain_d;
  logic [vcsp_pkg::WORD_W-1:0] dim0_q, dim0_d;
  logic [vcsp_pkg::WORD_W-1:0] dim1_q, dim1_d;
  logic [vcsp_pkg::BYTE_W-1:0] coord_q [3];
  logic [vcsp_pkg::BYTE_W-1:0] coord_d [3];
  logic [vcsp_pkg::WORD_W-1:0] pack_q, pack_d;
  logic [vcsp_pkg::WORD_W-1:0] models_q, models_d;
  logic                        have_q, have_d;

  // ---- result register ------------------------------------------------------
  logic           out_valid_q;
  vcsp_pkg::res_t out_q;

  // ---- step logic -----------------------------------------------------------
  vcsp_pkg::res_t              res;
  logic                        res_emit;
  logic                        advance;
  logic                        do_fail;
  logic                        do_finish;
  logic [vcsp_pkg::FAULT_W-1:0] fail_code;
  logic [vcsp_pkg::WORD_W-1:0] word;
  logic [vcsp_pkg::WORD_W-1:0] remain_dec;
  logic [vcsp_pkg::WORD_W-1:0] skip_len;
  logic [3:0]                  bpos_inc;
  logic                        word_done;

  assign remain_dec = remain_q - 32'd1;
  assign bpos_inc   = bpos_q + 4'd1;
  assign word_done  = (bpos_q[1:0] == 2'd3);
  assign skip_len   = clen_q[31] ? '0 : clen_q;

  // little-endian word assembly: byte lane picked by the low position bits
  always_comb begin
    unique case (bpos_q[1:0])
      2'd0:    word = {24'd0, byte_q};
      2'd1:    word = {acc_q[31:16], byte_q, acc_q[7:0]};
      2'd2:    word = {acc_q[31:24], byte_q, acc_q[15:0]};
      default: word = {byte_q, acc_q[23:0]};
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    bpos_d    = bpos_q;
    acc_d     = acc_q;
    ckind_d   = ckind_q;
    clen_d    = clen_q;
    remain_d  = remain_q;
    dim0_d    = dim0_q;
    dim1_d    = dim1_q;
    coord_d   = coord_q;
    pack_d    = pack_q;
    models_d  = models_q;
    have_d    = have_q;
    res       = '0;
    res_emit  = 1'b0;
    do_fail   = 1'b0;
    do_finish = 1'b0;
    fail_code = vcsp_pkg::FLT_BAD_MAGIC;

    if (in_valid_q && (phase_q != PH_HALT)) begin
      if (mode_q) begin
        // end of file: the phase decides between a fault and the final check
        unique case (phase_q)
          PH_MAGIC:   begin do_fail = 1'b1; fail_code = vcsp_pkg::FLT_BAD_MAGIC;   end
          PH_VERSION: begin do_fail = 1'b1; fail_code = vcsp_pkg::FLT_VERSION_EOF; end
          PH_HEADER: begin
            if (bpos_q < 4'd4) begin
              do_finish = 1'b1;
            end else begin
              do_fail   = 1'b1;
              fail_code = vcsp_pkg::FLT_HEADER_EOF;
            end
          end
          PH_PACK:    begin do_fail = 1'b1; fail_code = vcsp_pkg::FLT_PACK_EOF;    end
          PH_SIZE:    begin do_fail = 1'b1; fail_code = vcsp_pkg::FLT_SIZE_EOF;    end
          PH_COUNT:   begin do_fail = 1'b1; fail_code = vcsp_pkg::FLT_COUNT_EOF;   end
          PH_VOXEL:   begin do_fail = 1'b1; fail_code = vcsp_pkg::FLT_VOXEL_EOF;   end
          default:    do_finish = 1'b1;
        endcase
      end else if (phase_q == PH_SKIP) begin
        remain_d = remain_dec;
        if (remain_dec == '0) begin
          phase_d = PH_HEADER;
          bpos_d  = '0;
        end
      end else if (phase_q == PH_VOXEL) begin
        if (bpos_q < 4'd3) begin
          coord_d[bpos_q[1:0]] = byte_q;
          bpos_d = bpos_inc;
        end else begin
          bpos_d = '0;
          if (byte_q[7]) begin
            do_fail   = 1'b1;
            fail_code = vcsp_pkg::FLT_COLOR_NEG;
          end else begin
            res_emit   = 1'b1;
            res.kind   = vcsp_pkg::KIND_VOXEL;
            res.vox_x  = coord_q[0];
            res.vox_y  = coord_q[1];
            res.vox_z  = coord_q[2];
            res.colour = byte_q[6:0];
            remain_d   = remain_dec;
            if (remain_dec == '0) begin
              phase_d = PH_HEADER;
            end
          end
        end
      end else begin
        // word-assembling phases
        acc_d  = word;
        bpos_d = bpos_inc;
        if (word_done) begin
          unique case (phase_q)
            PH_MAGIC: begin
              if (word != vcsp_pkg::TAG_VOX) begin
                do_fail   = 1'b1;
                fail_code = vcsp_pkg::FLT_BAD_MAGIC;
              end else begin
                phase_d = PH_VERSION;
                bpos_d  = '0;
              end
            end
            PH_VERSION: begin
              phase_d = PH_HEADER;
              bpos_d  = '0;
            end
            PH_HEADER: begin
              if (bpos_inc == 4'd4) begin
                ckind_d = vcsp_pkg::classify(word);
              end else if (bpos_inc == 4'd8) begin
                clen_d = word;
              end else begin
                // header complete: dispatch on the chunk class
                bpos_d = '0;
                unique case (ckind_q)
                  vcsp_pkg::CK_MAIN: phase_d = PH_HEADER;
                  vcsp_pkg::CK_PACK: phase_d = PH_PACK;
                  vcsp_pkg::CK_SIZE: phase_d = PH_SIZE;
                  vcsp_pkg::CK_XYZI: begin
                    if (!have_q) begin
                      do_fail   = 1'b1;
                      fail_code = vcsp_pkg::FLT_VOX_NO_SIZE;
                    end else begin
                      phase_d = PH_COUNT;
                    end
                  end
                  default: begin
                    remain_d = skip_len;
                    phase_d  = (skip_len == '0) ? PH_HEADER : PH_SKIP;
                  end
                endcase
              end
            end
            PH_PACK: begin
              phase_d = PH_HEADER;
              bpos_d  = '0;
              if (pack_q == '0) begin
                pack_d = word;
              end else begin
                res_emit = 1'b1;
                res.kind = vcsp_pkg::KIND_DUPPK;
              end
            end
            PH_SIZE: begin
              if (bpos_inc == 4'd4) begin
                dim0_d = word;
              end else if (bpos_inc == 4'd8) begin
                dim1_d = word;
              end else if (dim0_q == '0 || dim0_q[31] || dim1_q == '0 || dim1_q[31] ||
                           word == '0 || word[31]) begin
                do_fail   = 1'b1;
                fail_code = vcsp_pkg::FLT_SIZE_NONPOS;
              end else begin
                have_d    = 1'b1;
                models_d  = models_q + 32'd1;
                phase_d   = PH_HEADER;
                bpos_d    = '0;
                res_emit  = 1'b1;
                res.kind  = vcsp_pkg::KIND_SIZE;
                res.dim_x = dim0_q[30:0];
                res.dim_y = dim1_q[30:0];
                res.dim_z = word[30:0];
              end
            end
            PH_COUNT: begin
              if (word == '0) begin
                do_fail   = 1'b1;
                fail_code = vcsp_pkg::FLT_ZERO_VOXELS;
              end else begin
                bpos_d = '0;
                if (word[31]) begin
                  phase_d = PH_HEADER;
                end else begin
                  remain_d = word;
                  phase_d  = PH_VOXEL;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // final check at end of file
      if (do_finish) begin
        if (!have_q) begin
          do_fail   = 1'b1;
          fail_code = vcsp_pkg::FLT_NO_MODELS;
        end else if (pack_q != '0 && pack_q != models_q) begin
          do_fail   = 1'b1;
          fail_code = vcsp_pkg::FLT_COUNT_MISM;
        end else begin
          phase_d         = PH_HALT;
          res_emit        = 1'b1;
          res.kind        = vcsp_pkg::KIND_DONE;
          res.models_seen = models_q;
        end
      end

      if (do_fail) begin
        phase_d   = PH_HALT;
        res_emit  = 1'b1;
        res       = '0;
        res.kind  = vcsp_pkg::KIND_ERROR;
        res.fault = fail_code;
      end
    end
  end

  // a word leaves the input register when its result (if any) has room
  assign advance    = in_valid_q && (!res_emit || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      mode_q <= in_i.mode;
      byte_q <= in_i.data_byte;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC;
      bpos_q   <= '0;
      acc_q    <= '0;
      ckind_q  <= vcsp_pkg::CK_OTHER;
      clen_q   <= '0;
      remain_q <= '0;
      dim0_q   <= '0;
      dim1_q   <= '0;
      coord_q  <= '{default: '0};
      pack_q   <= '0;
      models_q <= '0;
      have_q   <= 1'b0;
    end else if (advance) begin
      phase_q  <= phase_d;
      bpos_q   <= bpos_d;
      acc_q    <= acc_d;
      ckind_q  <= ckind_d;
      clen_q   <= clen_d;
      remain_q <= remain_d;
      dim0_q   <= dim0_d;
      dim1_q   <= dim1_d;
      coord_q  <= coord_d;
      pack_q   <= pack_d;
      models_q <= models_d;
      have_q   <= have_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_emit) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.dim_x       = out_q.dim_x;
  assign out_o.dim_y       = out_q.dim_y;
  assign out_o.dim_z       = out_q.dim_z;
  assign out_o.vox_x       = out_q.vox_x;
  assign out_o.vox_y       = out_q.vox_y;
  assign out_o.vox_z       = out_q.vox_z;
  assign out_o.colour      = out_q.colour;
  assign out_o.fault       = out_q.fault;
  assign out_o.models_seen = out_q.models_seen;

  // ---- assertions -----------------------------------------------------------
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALT |=> phase_q == PH_HALT)
    else $error("parser left halt without reset");

  a_voxel_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_VOXEL || phase_q == PH_SKIP) |-> remain_q != '0)
    else $error("counted phase with nothing remaining");

  a_voxel_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_VOXEL |-> bpos_q < 4'd4)
    else $error("voxel byte position out of range");

  a_done_has_model: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_emit && res.kind == vcsp_pkg::KIND_DONE) |-> have_q)
    else $error("done reported without a model");

  a_result_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_emit && (res.kind == vcsp_pkg::KIND_DONE ||
                             res.kind == vcsp_pkg::KIND_ERROR)) |=> phase_q == PH_HALT)
    else $error("final result without halt");

endmodule
